### hw/rtl/esd_pkg.sv
// Shared types and constants for the escape sequence decoder.
// Used by the front parser, the burst queue, the back serializer and the top level.
package esd_pkg;

  // Most bytes one input byte can produce: escape letter, seven digits, breaking byte
  localparam int MaxOut     = 9;
  localparam int CountW     = $clog2(MaxOut + 1);
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    MODE_PLAIN    = 3'd0,
    MODE_BSLASH   = 3'd1,
    MODE_OCT      = 3'd2,
    MODE_HEX_X    = 3'd3,
    MODE_HEX_U    = 3'd4,
    MODE_HEX_BIGU = 3'd5
  } mode_t;

  // All output bytes caused by one input byte
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CountW-1:0]      count;
    logic                   last;
  } burst_t;

endpackage

### hw/rtl/escape_sequence_decoder.sv
// C-style escape decoder with UTF-8 output. The block accepts one raw byte per cycle while its
// four-entry burst queue has room and gives the unescaped bytes one per cycle on the result
// side while out_stall is low. An input byte produces 0 to 9 output bytes, so the output
// serializer, not the parser, sets the sustained rate; for ordinary text each input byte
// gives one output byte. Escape flushes with several bytes drain through the queue
// while later input keeps arriving. There is no clearing pass after reset.
module escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end
);

  esd_pkg::burst_t wr_burst;
  esd_pkg::burst_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;

  esd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .burst    (wr_burst)
  );

  esd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_burst),
    .pop     (pop),
    .full    (q_full),
    .valid   (q_valid),
    .rd_data (head)
  );

  esd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

  // The last byte of a string always leaves at least one result behind
  a_last_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> out_valid)
    else $error("string end accepted without a pending result");

  // A burst is not retired before its final byte goes out
  a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_run_last |=> out_valid)
    else $error("burst dropped before its last byte");

  // Every push enters a queue that had room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full && in_valid)
    else $error("push into a full queue");

endmodule

### hw/rtl/esd_front.sv
// Front parser: accepts raw bytes, tracks the escape state and builds one burst per byte.
// Depends on esd_pkg for the mode type and the burst record.
module esd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            q_full,
  output logic            push,
  output esd_pkg::burst_t burst
);

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChBigU   = 8'h55;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } enc_t;

  function automatic enc_t encode(input logic [31:0] cp, input logic raw);
    enc_t e;
    e.b = '0;
    e.n = 3'd1;
    if (raw || cp < 32'h80) begin
      e.b[0] = cp[7:0];
    end else if (cp < 32'h800) begin
      e.n    = 3'd2;
      e.b[0] = 8'hC0 | {3'b000, cp[10:6]};
      e.b[1] = 8'h80 | {2'b00, cp[5:0]};
    end else if (cp < 32'h10000) begin
      e.n    = 3'd3;
      e.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
      e.b[1] = 8'h80 | {2'b00, cp[11:6]};
      e.b[2] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = 8'hF0 | cp[25:18];
      e.b[1] = 8'h80 | {2'b00, cp[17:12]};
      e.b[2] = 8'h80 | {2'b00, cp[11:6]};
      e.b[3] = 8'h80 | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b inside {["0":"9"]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {["a":"f"]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {["A":"F"]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  esd_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic [31:0]    code_r, code_nxt;
  logic [7:0]     dbuf_r [8];

  logic                        acc;
  logic                        wr_en;
  logic [4:0]                  hv;
  logic                        is_oct;
  logic [31:0]                 oct_code;
  logic [31:0]                 hex_code;
  logic [3:0]                  cnt_inc;
  logic [3:0]                  need;
  logic [7:0]                  letter;
  logic                        flush_en;
  logic [31:0]                 flush_cp;
  logic                        flush_raw;
  enc_t                        enc;
  logic                        plain_call;
  logic [7:0]                  main_b [8];
  logic [esd_pkg::CountW-1:0]  main_n;
  logic                        tail_v;

  assign acc      = in_valid && !in_stall;
  assign in_stall = q_full;
  assign hv       = hex_val(in_byte);
  assign is_oct   = in_byte inside {["0":"7"]};
  assign oct_code = {code_r[28:0], in_byte[2:0]};
  assign hex_code = {code_r[27:0], hv[3:0]};
  assign cnt_inc  = cnt_r + 4'd1;
  assign enc      = encode(flush_cp, flush_raw);

  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    code_nxt   = code_r;
    wr_en      = 1'b0;
    flush_en   = 1'b0;
    flush_cp   = code_r;
    flush_raw  = 1'b1;
    plain_call = 1'b0;
    main_n     = '0;
    tail_v     = 1'b0;
    need       = 4'd8;
    letter     = ChBigU;
    for (int i = 0; i < 8; i++) begin
      main_b[i] = 8'h00;
    end

    case (mode_r)
      esd_pkg::MODE_BSLASH: begin
        mode_nxt = esd_pkg::MODE_PLAIN;
        cnt_nxt  = 4'd0;
        code_nxt = 32'd0;
        if (is_oct) begin
          if (in_last) begin
            main_n    = esd_pkg::CountW'(1);
            main_b[0] = {5'b00000, in_byte[2:0]};
          end else begin
            mode_nxt = esd_pkg::MODE_OCT;
            cnt_nxt  = 4'd1;
            code_nxt = {29'd0, in_byte[2:0]};
          end
        end else if ((in_byte == ChLowX || in_byte == ChLowU || in_byte == ChBigU)
                     && !in_last) begin
          mode_nxt = (in_byte == ChLowX) ? esd_pkg::MODE_HEX_X :
                     (in_byte == ChLowU) ? esd_pkg::MODE_HEX_U : esd_pkg::MODE_HEX_BIGU;
        end else begin
          main_n = esd_pkg::CountW'(1);
          case (in_byte)
            "n":     main_b[0] = 8'h0A;
            "r":     main_b[0] = 8'h0D;
            "t":     main_b[0] = 8'h09;
            "v":     main_b[0] = 8'h0B;
            "f":     main_b[0] = 8'h0C;
            "b":     main_b[0] = 8'h08;
            "a":     main_b[0] = 8'h07;
            default: main_b[0] = in_byte;
          endcase
        end
      end

      esd_pkg::MODE_OCT: begin
        flush_en = 1'b1;
        if (is_oct) begin
          code_nxt = oct_code;
          cnt_nxt  = cnt_inc;
          flush_en = (cnt_inc >= 4'd3) || in_last;
          flush_cp = oct_code;
        end else begin
          plain_call = 1'b1;
        end
        flush_raw = (flush_cp <= 32'hFF);
        if (flush_en) begin
          mode_nxt = esd_pkg::MODE_PLAIN;
          cnt_nxt  = 4'd0;
          code_nxt = 32'd0;
        end
      end

      esd_pkg::MODE_HEX_X, esd_pkg::MODE_HEX_U, esd_pkg::MODE_HEX_BIGU: begin
        need   = (mode_r == esd_pkg::MODE_HEX_X) ? 4'd2 :
                 (mode_r == esd_pkg::MODE_HEX_U) ? 4'd4 : 4'd8;
        letter = (mode_r == esd_pkg::MODE_HEX_X) ? ChLowX :
                 (mode_r == esd_pkg::MODE_HEX_U) ? ChLowU : ChBigU;
        if (hv[4]) begin
          wr_en    = 1'b1;
          code_nxt = hex_code;
          cnt_nxt  = cnt_inc;
        end
        if (hv[4] && cnt_inc >= need) begin
          flush_en  = 1'b1;
          flush_cp  = hex_code;
          flush_raw = (mode_r == esd_pkg::MODE_HEX_X);
          mode_nxt  = esd_pkg::MODE_PLAIN;
          cnt_nxt   = 4'd0;
          code_nxt  = 32'd0;
        end else if (!hv[4] || in_last) begin
          // Give the run back literally: letter, then the digits held so far
          main_b[0] = letter;
          for (int i = 0; i < 7; i++) begin
            main_b[i+1] = (hv[4] && cnt_r[2:0] == 3'(i)) ? in_byte : dbuf_r[i];
          end
          main_n     = hv[4] ? esd_pkg::CountW'(cnt_inc + 4'd1)
                             : esd_pkg::CountW'(cnt_inc);
          plain_call = !hv[4];
          mode_nxt   = esd_pkg::MODE_PLAIN;
          cnt_nxt    = 4'd0;
          code_nxt   = 32'd0;
        end
      end

      default: begin
        mode_nxt   = esd_pkg::MODE_PLAIN;
        plain_call = 1'b1;
      end
    endcase

    if (flush_en) begin
      main_n = esd_pkg::CountW'(enc.n);
      for (int i = 0; i < 4; i++) begin
        main_b[i] = enc.b[i];
      end
    end

    // Breaking byte or ordinary text goes after whatever the run produced
    if (plain_call) begin
      if (in_byte == ChBslash && !in_last) begin
        mode_nxt = esd_pkg::MODE_BSLASH;
      end else begin
        tail_v = 1'b1;
      end
    end

    if (in_last) begin
      mode_nxt = esd_pkg::MODE_PLAIN;
      cnt_nxt  = 4'd0;
      code_nxt = 32'd0;
    end
  end

  always_comb begin
    for (int i = 0; i < esd_pkg::MaxOut; i++) begin
      if (i < 8 && esd_pkg::CountW'(i) < main_n) begin
        burst.bytes[i] = main_b[i[2:0]];
      end else begin
        burst.bytes[i] = in_byte;
      end
    end
    burst.count = main_n + esd_pkg::CountW'(tail_v);
    burst.last  = in_last;
  end

  assign push = acc && (burst.count != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= esd_pkg::MODE_PLAIN;
      cnt_r  <= 4'd0;
      code_r <= 32'd0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      code_r <= code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      dbuf_r[cnt_r[2:0]] <= in_byte;
    end
  end

endmodule

### hw/rtl/esd_queue.sv
// Short burst queue between the front parser and the back serializer.
// Depends on esd_pkg for the burst record and the queue depth.
module esd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  esd_pkg::burst_t wr_data,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output esd_pkg::burst_t rd_data
);

  esd_pkg::burst_t              mem [esd_pkg::QueueDepth];
  logic [esd_pkg::QPtrW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [esd_pkg::QPtrW:0]      fill_r, fill_nxt;

  assign full    = (fill_r == (esd_pkg::QPtrW+1)'(esd_pkg::QueueDepth));
  assign valid   = (fill_r != '0);
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hw/rtl/esd_back.sv
// Back serializer: sends the head burst out one byte per cycle while not stalled.
// Depends on esd_pkg for the burst record.
module esd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  esd_pkg::burst_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_end
);

  logic [esd_pkg::CountW-1:0] idx_r, idx_nxt;
  logic                       take;

  assign out_valid      = q_valid;
  assign out_byte       = head.bytes[idx_r];
  assign out_run_last   = (idx_r == head.count - 1'b1);
  assign out_string_end = out_run_last && head.last;
  assign take           = out_valid && !out_stall;
  assign pop            = take && out_run_last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = out_run_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

### tb/esd_checker.sv
// Checker for escape_sequence_decoder: watches both byte channels, predicts the
// decoded bytes of every accepted raw byte and compares them in order.
// Depends on esd_pkg for the parse mode encoding.
module esd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_run_last,
  input  logic       out_string_end,
  output int         fail_count,
  output int         open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] Backslash = 8'h5C;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } decoded_t;

  decoded_t    decoded_q[$];
  decoded_t    want;
  logic [7:0]  burst_q[$];

  // decoder state, mirrored
  esd_pkg::mode_t mode;
  int unsigned    held_digits;
  logic [7:0]     digit_text[8];
  logic [31:0]    code;

  task automatic report_mismatch(input string what);
    $display("esd_checker: %s", what);
    fail_count++;
  endtask

  function automatic void emit(logic [31:0] v);
    burst_q = {burst_q, v[7:0]};
  endfunction

  function automatic void emit_utf8(logic [31:0] cp);
    if (cp < 32'h80) begin
      emit(cp);
    end else if (cp < 32'h800) begin
      emit(32'hC0 | (cp >> 6));
      emit(32'h80 | (cp & 32'h3F));
    end else if (cp < 32'h10000) begin
      emit(32'hE0 | (cp >> 12));
      emit(32'h80 | ((cp >> 6) & 32'h3F));
      emit(32'h80 | (cp & 32'h3F));
    end else begin
      // lead byte keeps only its low 8 bits for large code points
      emit(32'hF0 | (cp >> 18));
      emit(32'h80 | ((cp >> 12) & 32'h3F));
      emit(32'h80 | ((cp >> 6) & 32'h3F));
      emit(32'h80 | (cp & 32'h3F));
    end
  endfunction

  function automatic int hex_nibble(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void restart();
    mode = esd_pkg::MODE_PLAIN;
    held_digits = 0;
    code = '0;
  endfunction

  function automatic void flush_octal();
    if (code <= 32'hFF) emit(code);
    else emit_utf8(code);
  endfunction

  function automatic void plain_byte(logic [7:0] b, logic last);
    if (b == Backslash) begin
      if (last) emit(32'(b));
      else mode = esd_pkg::MODE_BSLASH;
    end else begin
      emit(32'(b));
    end
  endfunction

  function automatic void escape_byte(logic [7:0] b, logic last);
    restart();
    case (b)
      "n": emit(32'h0A);
      "r": emit(32'h0D);
      "t": emit(32'h09);
      "v": emit(32'h0B);
      "f": emit(32'h0C);
      "b": emit(32'h08);
      "a": emit(32'h07);
      "0", "1", "2", "3", "4", "5", "6", "7": begin
        code = 32'(b - "0");
        held_digits = 1;
        mode = esd_pkg::MODE_OCT;
        if (last) begin
          flush_octal();
          restart();
        end
      end
      "x", "u", "U": begin
        if (last) emit(32'(b));
        else if (b == "x") mode = esd_pkg::MODE_HEX_X;
        else if (b == "u") mode = esd_pkg::MODE_HEX_U;
        else mode = esd_pkg::MODE_HEX_BIGU;
      end
      default: emit(32'(b));
    endcase
  endfunction

  function automatic void octal_byte(logic [7:0] b, logic last);
    if (b >= "0" && b <= "7") begin
      code = (code << 3) + 32'(b - "0");
      held_digits++;
      if (held_digits >= 3 || last) begin
        flush_octal();
        restart();
      end
    end else begin
      flush_octal();
      restart();
      plain_byte(b, last);
    end
  endfunction

  function automatic void hex_byte(logic [7:0] b, logic last);
    int unsigned need;
    logic [7:0]  letter;
    int          v;
    need   = (mode == esd_pkg::MODE_HEX_X) ? 2 : (mode == esd_pkg::MODE_HEX_U) ? 4 : 8;
    letter = (mode == esd_pkg::MODE_HEX_X) ? "x" : (mode == esd_pkg::MODE_HEX_U) ? "u" : "U";
    v      = hex_nibble(b);
    if (v >= 0) begin
      digit_text[held_digits % 8] = b;
      code = (code << 4) | 32'(v);
      held_digits++;
      if (held_digits >= need) begin
        if (mode == esd_pkg::MODE_HEX_X) emit(code);
        else emit_utf8(code);
        restart();
        return;
      end
      if (!last) return;
    end
    // short or broken run: give the letter and the digits literally
    emit(32'(letter));
    for (int i = 0; i < held_digits && i < 8; i++) emit(32'(digit_text[i]));
    restart();
    if (v < 0) plain_byte(b, last);
  endfunction

  function automatic void decode_request(logic [7:0] b, logic last);
    decoded_t d;
    burst_q.delete();
    case (mode)
      esd_pkg::MODE_BSLASH: escape_byte(b, last);
      esd_pkg::MODE_OCT: octal_byte(b, last);
      esd_pkg::MODE_HEX_X, esd_pkg::MODE_HEX_U, esd_pkg::MODE_HEX_BIGU: hex_byte(b, last);
      default: begin
        mode = esd_pkg::MODE_PLAIN;
        plain_byte(b, last);
      end
    endcase
    if (last) restart();
    foreach (burst_q[k]) begin
      d.data       = burst_q[k];
      d.run_last   = (k == burst_q.size() - 1);
      d.string_end = d.run_last && last;
      decoded_q = {decoded_q, d};
    end
  endfunction

  // Sample between edges: everything driven at the rising edge has settled.
  always @(negedge clk) begin
    if (!rst_n) begin
      restart();
      decoded_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_request(in_byte, in_last);
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h run_last %b string_end %b",
                                    out_byte, out_run_last, out_string_end));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data || out_run_last !== want.run_last ||
              out_string_end !== want.string_end) begin
            report_mismatch($sformatf("got byte %h run_last %b string_end %b, want %h %b %b",
                                      out_byte, out_run_last, out_string_end,
                                      want.data, want.run_last, want.string_end));
          end
        end
      end
    end
    open_count = decoded_q.size();
  end

endmodule

### tb/tb_top.sv
// Top of the escape_sequence_decoder testbench: clock, reset, raw string requests
// and output stalls. Prediction and comparison live in esd_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HalfPeriod = 4;
  localparam int         ItemTarget = 370;
  localparam int         QuietLimit = 4000;
  localparam int         DrainWait  = 20;
  localparam logic [7:0] Backslash  = 8'h5C;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = '0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_string_end;

  int         fail_count;
  int         open_count;
  int         items_sent = 0;
  int         idle_pct = 14;
  int         stall_pct = 80;
  int         quiet_cycles = 0;
  logic [7:0] text_q[$];

  always #HalfPeriod clk = ~clk;

  escape_sequence_decoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

  esd_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .fail_count     (fail_count),
    .open_count     (open_count)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // End the run once nothing moves on either channel for too long.
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [7:0] hex_char();
    string hex_set;
    hex_set = "0123456789abcdefABCDEF";
    return hex_set[$urandom_range(21)];
  endfunction

  // Append one raw byte to the pending string.
  task automatic queue_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  // Send the queued string, last mark on its final byte.
  task automatic send_text();
    foreach (text_q[i]) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= text_q[i];
      in_last  <= (i == text_q.size() - 1);
      @(negedge clk);
      while (in_stall) @(negedge clk);
      @(posedge clk);
      items_sent++;
    end
    text_q.delete();
  endtask

  initial begin : stimulus
    string simple_set;
    string letter_set;
    int    kind;
    int    span;
    int    keep;
    simple_set = "nrtvfba\\\"'?";
    letter_set = "xuU";
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // byte extremes, a simple escape, an escape of a non-special byte
    queue_byte(8'h00);
    queue_byte(8'hFF);
    add_text("\\n\\9");
    send_text();
    // three-digit octal, then an octal run broken by a letter
    add_text("\\101\\7z");
    send_text();
    // hex run cut short by the end of the string
    add_text("\\x4");
    send_text();
    add_text("\\u20ac");
    send_text();
    // escape letter on the final byte
    add_text("\\U");
    send_text();
    // trailing backslash
    add_text("\\");
    send_text();

    while (items_sent < ItemTarget) begin
      if (items_sent >= 2 * ItemTarget / 3) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else if (items_sent >= ItemTarget / 3) begin
        idle_pct  = 80;
        stall_pct = 14;
      end
      repeat ($urandom_range(6, 1)) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          queue_byte(8'($urandom_range(255)));
        end else if (kind < 50) begin
          queue_byte(Backslash);
          queue_byte(simple_set[$urandom_range(10)]);
        end else if (kind < 60) begin
          queue_byte(Backslash);
          repeat ($urandom_range(3, 1)) queue_byte(8'h30 + 8'($urandom_range(7)));
        end else if (kind < 84) begin
          // complete \x, \u or \U run
          span = (kind < 68) ? 0 : (kind < 76) ? 1 : 2;
          queue_byte(Backslash);
          queue_byte(letter_set[span]);
          repeat (2 << span) queue_byte(hex_char());
        end else if (kind < 94) begin
          // short run followed by an arbitrary byte, which may break it
          span = $urandom_range(2);
          queue_byte(Backslash);
          queue_byte(letter_set[span]);
          repeat ($urandom_range((2 << span) - 1, 0)) queue_byte(hex_char());
          queue_byte(8'($urandom_range(255)));
        end else begin
          queue_byte(Backslash);
          queue_byte(8'($urandom_range(255)));
        end
      end
      // cut some strings short, possibly mid-escape, so held digits get flushed at the end
      if ($urandom_range(99) < 15) begin
        keep = $urandom_range(text_q.size(), 1);
        while (text_q.size() > keep) void'(text_q.pop_back());
      end
      send_text();
    end
    in_valid <= 1'b0;

    while (open_count != 0) @(negedge clk);
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### escape_sequence_decoder.f
hw/rtl/esd_pkg.sv
hw/rtl/esd_front.sv
hw/rtl/esd_queue.sv
hw/rtl/esd_back.sv
hw/rtl/escape_sequence_decoder.sv
tb/esd_checker.sv
tb/tb_top.sv
